@@ rtl/polygon_min_corner_angle_defines.svh @@
// Assertion macros for the polygon minimum corner angle block.
// Used by the top level only; no other dependencies.
`ifndef POLYGON_MIN_CORNER_ANGLE_DEFINES_SVH
`define POLYGON_MIN_CORNER_ANGLE_DEFINES_SVH

// Property that must hold on every clock edge outside reset.
`define PMCA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property that must hold on every clock edge, reset included.
`define PMCA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ rtl/pmca_pkg.sv @@
// Package for the polygon minimum corner angle block: types, constants, CORDIC table.
// Used by pmca_datapath, pmca_ctrl and polygon_min_corner_angle.
package pmca_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int COUNT_BITS = 8;
   localparam int Z_BITS     = 34;
   localparam int NORM_BITS  = 43;
   localparam int TAB_LEN    = 24;
   localparam int ITER_BITS  = 5;

   localparam logic signed [ANGLE_BITS-1:0] ANGLE_MAX = 16'sd32767;

   typedef enum logic [2:0] {
      CORNER_NEW   = 3'b001,
      CORNER_CLOSE = 3'b010,
      CORNER_WRAP  = 3'b100
   } corner_sel_type;

   typedef struct packed {
      logic           take_item;
      logic           start;
      corner_sel_type sel;
      logic           clear_face;
   } dp_cmd_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [COUNT_BITS-1:0] count;
   } dp_status_type;

   function automatic logic [Z_BITS-1:0] atan_entry(input logic [ITER_BITS-1:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2F9;
         5'd15: v = 32'h0000517C;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A2F;
         5'd19: v = 32'h00000517;
         5'd20: v = 32'h0000028B;
         5'd21: v = 32'h00000145;
         5'd22: v = 32'h000000A2;
         5'd23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return {2'b00, v};
   endfunction

endpackage

@@ rtl/polygon_min_corner_angle.sv @@
// Top level of the polygon minimum corner angle block.
// Depends on pmca_pkg, pmca_ctrl, pmca_datapath and polygon_min_corner_angle_defines.svh.
//
//   Channel | Direction | Contents
//   req_    | in        | x_coord, y_coord, last_vertex
//   rsp_    | out       | min_angle, vertex_count, too_few
//
// A vertex that closes a corner runs the edge, product, normalize, CORDIC and round
// steps, normalizing longer when the products are large; the last vertex runs two
// more corners in sequence. The single shared CORDIC unit does one rotation per cycle.
// The first two vertices of a face are only stored; a vertex waits while a corner runs.
// Reset is synchronous and active high and clears the count and the running minimum.
// A result waits in its register until taken; only the next face result waits on it.
`include "polygon_min_corner_angle_defines.svh"
module polygon_min_corner_angle import pmca_pkg::*; #(
   parameter int COORD_BITS       = 24,
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_x_coord,
   input  logic signed [COORD_BITS-1:0] req_y_coord,
   input  logic                         req_last_vertex,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [ANGLE_BITS-1:0] rsp_min_angle,
   output logic [COUNT_BITS-1:0]        rsp_vertex_count,
   output logic                         rsp_too_few
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic rsp_load, rsp_short;
   logic signed [ANGLE_BITS-1:0] min_angle;
   logic signed [ANGLE_BITS-1:0] angle_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic short_ff;

   pmca_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_last_vertex, .req_ready,
      .rsp_valid, .rsp_ready, .rsp_load, .rsp_short, .status, .cmd
   );

   pmca_datapath #(
      .COORD_BITS(COORD_BITS), .ANGLE_ITERATIONS(ANGLE_ITERATIONS)
   ) u_dp (
      .clock, .reset, .x_coord(req_x_coord), .y_coord(req_y_coord),
      .cmd, .status, .min_angle
   );

   // The result is loaded after the last vertex has been counted.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         angle_ff <= rsp_short ? '0 : min_angle;
         count_ff <= status.count;
         short_ff <= rsp_short;
      end
   end

   assign rsp_min_angle    = angle_ff;
   assign rsp_vertex_count = count_ff;
   assign rsp_too_few      = short_ff;

   `PMCA_ASSERT(a_no_accept_while_busy, status.busy |-> !req_ready, "accepted while busy")
   `PMCA_ASSERT(a_short_count, (rsp_valid && rsp_too_few) |-> (rsp_vertex_count < 8'd3), "short face count")
   `PMCA_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "result after reset")

endmodule

@@ rtl/pmca_datapath.sv @@
// Datapath: vertex registers, edge products, normalization and iterative CORDIC.
// Depends on pmca_pkg.
module pmca_datapath import pmca_pkg::*; #(
   parameter int COORD_BITS       = 24,
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [COORD_BITS-1:0] x_coord,
   input  logic signed [COORD_BITS-1:0] y_coord,
   input  dp_cmd_type                   cmd,
   output dp_status_type                status,
   output logic signed [ANGLE_BITS-1:0] min_angle
);

   localparam int SHIFT  = (COORD_BITS > 29) ? (COORD_BITS - 29) : 0;
   localparam int DB     = COORD_BITS + 1 - SHIFT;   // edge vector width
   localparam int NITER  = (ANGLE_ITERATIONS < TAB_LEN) ? ANGLE_ITERATIONS : TAB_LEN;
   localparam int PHB    = 2 * DB + 1;               // product width
   localparam logic signed [63:0] NORM_LIMIT = 64'sd1 <<< 40;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_EDGE = 6'b000010,
      PH_PROD = 6'b000100,
      PH_NORM = 6'b001000,
      PH_ITER = 6'b010000,
      PH_ROUND = 6'b100000
   } phase_type;

   logic signed [COORD_BITS-1:0] first_x_ff, first_y_ff, second_x_ff, second_y_ff;
   logic signed [COORD_BITS-1:0] older_x_ff, older_y_ff, newer_x_ff, newer_y_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic signed [ANGLE_BITS-1:0] min_ff, min_in;
   phase_type phase_ff, phase_in;

   logic signed [DB-1:0] ux_ff, uy_ff, vx_ff, vy_ff;
   logic zero_edge_ff;
   logic signed [PHB-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [NORM_BITS-1:0] cx_ff, cy_ff;
   logic signed [Z_BITS-1:0] z_ff;
   logic [ITER_BITS-1:0] iter_ff;
   logic signed [PHB:0] nx_ff, ny_ff;
   logic zero_ff;

   // corner operand selection
   logic signed [COORD_BITS-1:0] ax, ay, bx, by, qx, qy;
   always_comb begin
      case (cmd.sel)
         CORNER_NEW: begin
            ax = older_x_ff; ay = older_y_ff; bx = newer_x_ff; by = newer_y_ff;
            qx = x_coord; qy = y_coord;
         end
         CORNER_CLOSE: begin
            ax = older_x_ff; ay = older_y_ff; bx = newer_x_ff; by = newer_y_ff;
            qx = first_x_ff; qy = first_y_ff;
         end
         default: begin
            ax = newer_x_ff; ay = newer_y_ff; bx = first_x_ff; by = first_y_ff;
            qx = second_x_ff; qy = second_y_ff;
         end
      endcase
   end

   logic signed [COORD_BITS:0] dux, duy, dvx, dvy;
   assign dux = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
   assign duy = {ay[COORD_BITS-1], ay} - {by[COORD_BITS-1], by};
   assign dvx = {qx[COORD_BITS-1], qx} - {bx[COORD_BITS-1], bx};
   assign dvy = {qy[COORD_BITS-1], qy} - {by[COORD_BITS-1], by};

   // normalization shift of one bit per cycle, floor
   logic signed [63:0] nx_w, ny_w;
   logic big;
   assign nx_w = 64'(nx_ff);
   assign ny_w = 64'(ny_ff);
   assign big = (nx_w >= NORM_LIMIT) || (nx_w <= -NORM_LIMIT)
             || (ny_w >= NORM_LIMIT) || (ny_w <= -NORM_LIMIT);

   logic signed [NORM_BITS-1:0] sx, sy;
   logic signed [Z_BITS-1:0] tab;
   assign sx = cx_ff >>> iter_ff;
   assign sy = cy_ff >>> iter_ff;
   assign tab = $signed(atan_entry(iter_ff));

   logic signed [Z_BITS-1:0] zr;
   logic signed [Z_BITS-ANGLE_BITS-1:0] q;
   logic signed [ANGLE_BITS-1:0] ang;
   assign zr = z_ff + Z_BITS'(32768);
   assign q = $signed(zr[Z_BITS-1:16]);
   always_comb begin
      if (zero_ff) ang = '0;
      else if (q > 18'sd32767) ang = 16'sd32767;
      else if (q < -18'sd32768) ang = -16'sd32768;
      else ang = q[ANGLE_BITS-1:0];
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      min_in = min_ff;
      if (cmd.take_item && count_ff != {COUNT_BITS{1'b1}}) count_in = count_ff + 1'b1;
      case (phase_ff)
         PH_IDLE:  if (cmd.start) phase_in = PH_EDGE;
         PH_EDGE:  phase_in = PH_PROD;
         PH_PROD:  phase_in = PH_NORM;
         PH_NORM:  if (!big) phase_in = PH_ITER;
         PH_ITER:  if (iter_ff == ITER_BITS'(NITER - 1)) phase_in = PH_ROUND;
         PH_ROUND: begin
            phase_in = PH_IDLE;
            if (ang < min_ff) min_in = ang;
         end
         default:  phase_in = PH_IDLE;
      endcase
      if (cmd.clear_face) begin
         count_in = '0;
         min_in = ANGLE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         min_ff <= ANGLE_MAX;
         first_x_ff <= '0; first_y_ff <= '0; second_x_ff <= '0; second_y_ff <= '0;
         older_x_ff <= '0; older_y_ff <= '0; newer_x_ff <= '0; newer_y_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         min_ff <= min_in;
         if (cmd.take_item) begin
            if (count_ff == '0) begin
               first_x_ff <= x_coord; first_y_ff <= y_coord;
            end
            if (count_ff == COUNT_BITS'(1)) begin
               second_x_ff <= x_coord; second_y_ff <= y_coord;
            end
            older_x_ff <= newer_x_ff; older_y_ff <= newer_y_ff;
            newer_x_ff <= x_coord; newer_y_ff <= y_coord;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         ux_ff <= DB'(dux >>> SHIFT);
         uy_ff <= DB'(duy >>> SHIFT);
         vx_ff <= DB'(dvx >>> SHIFT);
         vy_ff <= DB'(dvy >>> SHIFT);
         zero_edge_ff <= (dux == '0 && duy == '0) || (dvx == '0 && dvy == '0);
      end
      case (phase_ff)
         PH_EDGE: begin
            p0_ff <= PHB'(ux_ff * vy_ff);
            p1_ff <= PHB'(uy_ff * vx_ff);
            p2_ff <= PHB'(ux_ff * vx_ff);
            p3_ff <= PHB'(uy_ff * vy_ff);
         end
         PH_PROD: begin
            ny_ff <= (PHB+1)'(p0_ff) - (PHB+1)'(p1_ff);
            nx_ff <= (PHB+1)'(p2_ff) + (PHB+1)'(p3_ff);
            zero_ff <= zero_edge_ff;
         end
         PH_NORM: begin
            if (nx_ff == '0 && ny_ff == '0) zero_ff <= 1'b1;
            if (big) begin
               nx_ff <= nx_ff >>> 1;
               ny_ff <= ny_ff >>> 1;
            end else begin
               iter_ff <= '0;
               if (nx_ff < 0) begin
                  cx_ff <= -NORM_BITS'(nx_ff);
                  cy_ff <= -NORM_BITS'(ny_ff);
                  z_ff <= (ny_ff >= 0) ? Z_BITS'(64'sh80000000) : -Z_BITS'(64'sh80000000);
               end else begin
                  cx_ff <= NORM_BITS'(nx_ff);
                  cy_ff <= NORM_BITS'(ny_ff);
                  z_ff <= '0;
               end
            end
         end
         PH_ITER: begin
            iter_ff <= iter_ff + 1'b1;
            if (cy_ff > 0) begin
               cx_ff <= cx_ff + sy; cy_ff <= cy_ff - sx; z_ff <= z_ff + tab;
            end else if (cy_ff < 0) begin
               cx_ff <= cx_ff - sy; cy_ff <= cy_ff + sx; z_ff <= z_ff - tab;
            end
         end
         default: ;
      endcase
   end

   assign status.busy  = (phase_ff != PH_IDLE);
   assign status.done  = (phase_ff == PH_ROUND);
   assign status.count = count_ff;
   assign min_angle    = min_ff;

endmodule

@@ rtl/pmca_ctrl.sv @@
// Controller: sequences the corners of each vertex and the result handshake.
// Depends on pmca_pkg.
module pmca_ctrl import pmca_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last_vertex,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_load,
   output logic          rsp_short,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_NEW   = 5'b00010,
      ST_CLOSE = 5'b00100,
      ST_WRAP  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic last_ff, last_in, rv_ff, rv_in;
   logic accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      rv_in = rv_ff;
      cmd = '{take_item: 1'b0, start: 1'b0, sel: CORNER_NEW, clear_face: 1'b0};
      rsp_load = 1'b0;
      rsp_short = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         ST_IDLE: if (accept) begin
            cmd.take_item = 1'b1;
            last_in = req_last_vertex;
            if (status.count >= COUNT_BITS'(2)) begin
               cmd.start = 1'b1;
               state_in = ST_NEW;
            end else if (req_last_vertex) begin
               // A short face has no corners; its result goes out from the wrap state.
               last_in = 1'b0;
               state_in = ST_WRAP;
            end
         end
         ST_NEW: if (status.done) begin
            if (last_ff) state_in = ST_OUT;
            else state_in = ST_IDLE;
         end
         ST_OUT: begin
            cmd.start = 1'b1; cmd.sel = CORNER_CLOSE; state_in = ST_CLOSE;
         end
         ST_CLOSE: if (status.done) begin
            state_in = ST_WRAP;
         end
         ST_WRAP: if (!status.busy) begin
            if (last_ff) begin
               cmd.start = 1'b1; cmd.sel = CORNER_WRAP;
               last_in = 1'b0;
            end else if (!rv_ff || rsp_ready) begin
               // The minimum now holds every corner; load it once the output is free.
               rsp_load = 1'b1;
               rsp_short = (status.count < COUNT_BITS'(3));
               rv_in = 1'b1;
               cmd.clear_face = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
         rv_ff <= rv_in;
      end
   end

endmodule

@@ dv/tb_polygon_min_corner_angle.sv @@
// Self-checking testbench for polygon_min_corner_angle: vertex streams in, face minima out.
// Depends on pmca_pkg and the RTL of the block; the predictor below is self-contained.
module tb_polygon_min_corner_angle import pmca_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS = 24;
   localparam int ITERATIONS = 16;
   localparam int RANDOM_ITEMS = 1100;
   localparam longint HALF_TURN = 64'sh80000000;
   localparam longint NORM_CAP = 64'sd1 << 40;
   localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN = -(1 << (COORD_BITS - 1));

   // One face result as the block should report it.
   typedef struct {
      logic signed [ANGLE_BITS-1:0] min_angle;
      logic [COUNT_BITS-1:0]        vertex_count;
      logic                         too_few;
   } face_result_type;

   // One row of the directed stimulus. When typed is set the expected result
   // is taken from the row itself instead of the predictor.
   typedef struct {
      int   x;
      int   y;
      logic last;
      logic typed;
      int   angle;
      int   vcount;
      logic few;
   } vertex_row_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic signed [COORD_BITS-1:0] req_x_coord;
   logic signed [COORD_BITS-1:0] req_y_coord;
   logic                         req_last_vertex;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [ANGLE_BITS-1:0] rsp_min_angle;
   logic [COUNT_BITS-1:0]        rsp_vertex_count;
   logic                         rsp_too_few;

   polygon_min_corner_angle DUT (.*);

   // Arctangent steps in units of pi/2^31.
   localparam longint ATAN_STEP [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
      64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
   };

   face_result_type pending_faces[$];
   int              failures = 0;
   int              vertices_sent = 0;
   int              faces_checked = 0;
   int              accepted = 0;
   logic            calm = 1'b0;
   logic            row_typed = 1'b0;
   face_result_type row_result;

   // Shadow of the block's face state.
   longint first_x, first_y, second_x, second_y;
   longint older_x, older_y, newer_x, newer_y;
   int     face_min;
   int     face_count;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Signed angle at B from BA to BC, in units of pi/32768.
   function automatic int corner_angle(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy);
      longint ux, uy, vx, vy, px, py, nx, ny, z, q;
      ux = ax - bx;
      uy = ay - by;
      vx = cx - bx;
      vy = cy - by;
      if ((ux == 0 && uy == 0) || (vx == 0 && vy == 0)) return 0;
      px = ux * vx + uy * vy;
      py = ux * vy - uy * vx;
      if (px == 0 && py == 0) return 0;
      while (px >= NORM_CAP || px <= -NORM_CAP || py >= NORM_CAP || py <= -NORM_CAP) begin
         px = px >>> 1;
         py = py >>> 1;
      end
      z = 0;
      // A vector in the left half plane is turned by half a revolution first.
      if (px < 0) begin
         z = (py >= 0) ? HALF_TURN : -HALF_TURN;
         px = -px;
         py = -py;
      end
      for (int i = 0; i < ITERATIONS; i++) begin
         nx = px;
         ny = py;
         if (py > 0) begin
            nx = px + (py >>> i);
            ny = py - (px >>> i);
            z += ATAN_STEP[i];
         end else if (py < 0) begin
            nx = px - (py >>> i);
            ny = py + (px >>> i);
            z -= ATAN_STEP[i];
         end
         px = nx;
         py = ny;
      end
      q = (z + 32768) >>> 16;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return int'(q);
   endfunction

   function automatic void fold_min(int a);
      if (a < face_min) face_min = a;
   endfunction

   // Advance the shadow state by one vertex; returns 1 and the face result
   // when the vertex closes the face.
   function automatic bit face_step(longint x, longint y, logic last,
                                    output face_result_type r);
      if (face_count == 0) begin
         first_x = x;
         first_y = y;
      end else if (face_count == 1) begin
         second_x = x;
         second_y = y;
      end else begin
         fold_min(corner_angle(older_x, older_y, newer_x, newer_y, x, y));
      end
      older_x = newer_x;
      older_y = newer_y;
      newer_x = x;
      newer_y = y;
      if (face_count < 255) face_count++;
      if (!last) return 0;
      if (face_count < 3) begin
         r.min_angle = '0;
         r.too_few = 1'b1;
      end else begin
         // The wrap-around corners: at the last vertex and at the first one.
         fold_min(corner_angle(older_x, older_y, newer_x, newer_y, first_x, first_y));
         fold_min(corner_angle(newer_x, newer_y, first_x, first_y, second_x, second_y));
         r.min_angle = face_min[ANGLE_BITS-1:0];
         r.too_few = 1'b0;
      end
      r.vertex_count = face_count[COUNT_BITS-1:0];
      face_count = 0;
      face_min = 32767;
      return 1;
   endfunction

   // Both channels are observed at the rising edge. An accepted vertex goes
   // through the predictor; an accepted face result is checked against the
   // oldest pending expectation.
   always @(posedge clock) begin
      face_result_type want;
      face_result_type got;
      if (!reset && req_valid && req_ready) begin
         if (face_step(req_x_coord, req_y_coord, req_last_vertex, want)) begin
            if (row_typed) want = row_result;
            pending_faces.push_back(want);
         end
         accepted++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got.min_angle = rsp_min_angle;
         got.vertex_count = rsp_vertex_count;
         got.too_few = rsp_too_few;
         if (pending_faces.size() == 0) begin
            $error("unexpected result transaction: min_angle %0d count %0d",
                   got.min_angle, got.vertex_count);
            failures++;
         end else begin
            want = pending_faces.pop_front();
            if (got.min_angle !== want.min_angle) begin
               $error("min_angle: expected %0d, got %0d", want.min_angle, got.min_angle);
               failures++;
            end
            if (got.vertex_count !== want.vertex_count) begin
               $error("vertex_count: expected %0d, got %0d",
                      want.vertex_count, got.vertex_count);
               failures++;
            end
            if (got.too_few !== want.too_few) begin
               $error("too_few: expected %0d, got %0d", want.too_few, got.too_few);
               failures++;
            end
         end
         faces_checked++;
      end
   end

   // The receiver stalls about one cycle in five, except during the calm stretch.
   always @(negedge clock) begin
      rsp_ready = calm ? 1'b1 : ($urandom_range(99) >= 20);
   end

   // Present one vertex at a falling edge and hold it until the transaction
   // completes. Valid stays up into the next vertex unless an idle gap is drawn.
   task automatic send_vertex(int x, int y, logic last);
      int seen;
      while (!calm && $urandom_range(99) < 20) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_x_coord = x[COORD_BITS-1:0];
      req_y_coord = y[COORD_BITS-1:0];
      req_last_vertex = last;
      seen = accepted;
      wait (accepted != seen);
      vertices_sent++;
      @(negedge clock);
   endtask

   function automatic int pick_coord(int mode);
      case (mode)
         0: return $urandom_range(COORD_MAX);
         1: return COORD_MIN + int'($urandom_range(COORD_MAX));
         default: return int'($urandom_range(2000)) - 1000;
      endcase
   endfunction

   vertex_row_type directed [] = '{
      // A single vertex is a short face.
      '{COORD_MAX, COORD_MIN, 1'b1, 1'b1, 0, 1, 1'b1},
      // Two vertices are still a short face.
      '{COORD_MIN, COORD_MAX, 1'b0, 1'b0, 0, 0, 1'b0},
      '{COORD_MAX, COORD_MAX, 1'b1, 1'b1, 0, 2, 1'b1},
      // A square of side 1000 in both windings.
      '{0, 0, 1'b0, 1'b0, 0, 0, 1'b0},
      '{1000, 0, 1'b0, 1'b0, 0, 0, 1'b0},
      '{1000, 1000, 1'b0, 1'b0, 0, 0, 1'b0},
      '{0, 1000, 1'b1, 1'b0, 0, 0, 1'b0},
      '{0, 0, 1'b0, 1'b0, 0, 0, 1'b0},
      '{0, 1000, 1'b0, 1'b0, 0, 0, 1'b0},
      '{1000, 1000, 1'b0, 1'b0, 0, 0, 1'b0},
      '{1000, 0, 1'b1, 1'b0, 0, 0, 1'b0},
      // Every vertex the same: all edges have zero length.
      '{5, -7, 1'b0, 1'b0, 0, 0, 1'b0},
      '{5, -7, 1'b0, 1'b0, 0, 0, 1'b0},
      '{5, -7, 1'b1, 1'b1, 0, 3, 1'b0},
      // Collinear points give straight corners and folded-back ones.
      '{-100, 0, 1'b0, 1'b0, 0, 0, 1'b0},
      '{0, 0, 1'b0, 1'b0, 0, 0, 1'b0},
      '{100, 0, 1'b0, 1'b0, 0, 0, 1'b0},
      '{200, 0, 1'b1, 1'b0, 0, 0, 1'b0},
      // Full-range pentagon exercises product normalization.
      '{COORD_MIN, COORD_MIN, 1'b0, 1'b0, 0, 0, 1'b0},
      '{COORD_MAX, COORD_MIN, 1'b0, 1'b0, 0, 0, 1'b0},
      '{COORD_MAX, COORD_MAX, 1'b0, 1'b0, 0, 0, 1'b0},
      '{COORD_MIN, COORD_MAX, 1'b0, 1'b0, 0, 0, 1'b0},
      '{0, 1, 1'b1, 1'b0, 0, 0, 1'b0}
   };

   initial begin
      int face_len;
      int mode;
      int px, py;
      reset = 1'b1;
      req_valid = 1'b0;
      req_x_coord = '0;
      req_y_coord = '0;
      req_last_vertex = 1'b0;
      rsp_ready = 1'b0;
      first_x = 0; first_y = 0; second_x = 0; second_y = 0;
      older_x = 0; older_y = 0; newer_x = 0; newer_y = 0;
      face_min = 32767;
      face_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         row_typed = directed[i].typed;
         row_result.min_angle = directed[i].angle[ANGLE_BITS-1:0];
         row_result.vertex_count = directed[i].vcount[COUNT_BITS-1:0];
         row_result.too_few = directed[i].few;
         send_vertex(directed[i].x, directed[i].y, directed[i].last);
      end
      row_typed = 1'b0;

      // Hold the sender off until every directed face has been reported.
      req_valid = 1'b0;
      wait (pending_faces.size() == 0);
      @(negedge clock);

      // Random faces: mostly closed polygons of a few vertices, with repeated
      // vertices, short faces and one face longer than the count can hold.
      while (vertices_sent < RANDOM_ITEMS + directed.size()) begin
         calm = (vertices_sent > 400 && vertices_sent < 600);
         if ($urandom_range(99) < 2 || (vertices_sent > 700 && vertices_sent < 720))
            face_len = (vertices_sent > 700 && vertices_sent < 720) ? 300 : 1;
         else if ($urandom_range(99) < 10)
            face_len = $urandom_range(2, 1);
         else
            face_len = $urandom_range(12, 3);
         mode = $urandom_range(2);
         px = pick_coord(mode);
         py = pick_coord(mode);
         for (int k = 0; k < face_len; k++) begin
            if ($urandom_range(99) >= 8) begin
               px = pick_coord(mode);
               py = pick_coord(mode);
            end
            send_vertex(px, py, k == face_len - 1);
         end
      end
      calm = 1'b0;
      req_valid = 1'b0;

      wait (pending_faces.size() == 0);
      repeat (200) @(posedge clock);
      $display("Checked %0d faces built from %0d vertices, short and long faces included.",
               faces_checked, vertices_sent);
      if (failures == 0 && pending_faces.size() == 0)
         $display("tb_polygon_min_corner_angle passed");
      else
         $display("tb_polygon_min_corner_angle failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_polygon_min_corner_angle failed");
      $finish;
   end

endmodule
